FILE: src/rtss_pkg.sv
// shared types and constants of the record table sort/search block
// table depth, record layout, action codes, controller-to-datapath commands
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rtss_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DUMP   = 2'd1;
    localparam logic [1:0] ACT_SORT   = 2'd2;
    localparam logic [1:0] ACT_SEARCH = 2'd3;

    typedef struct packed {
        logic [15:0] num;
        logic [31:0] name;
        logic [7:0]  sex;
        logic [7:0]  age;
    } record_t;

    typedef struct packed {
        logic insert;
        logic latch_key;
        logic clear_hit;
        logic sort_step;
        logic sort_odd;
        logic rotate;
        logic scan;
        logic load_dump;
        logic dump_last;
        logic load_search;
    } cmd_t;

endpackage

`default_nettype wire

FILE: src/rtss_datapath.sv
// record table datapath: table registers, ring write pointer, odd-even
// compare/swap row, rotating read-out, search hit capture and output register
// depends on rtss_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtss_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire rtss_pkg::cmd_t cmd,
    input  wire logic [15:0]   rec_num,
    input  wire logic [31:0]   rec_name,
    input  wire logic [7:0]    rec_sex,
    input  wire logic [7:0]    rec_age,
    input  wire logic [15:0]   search_key,
    output logic [15:0]        out_num,
    output logic [31:0]        out_name,
    output logic [7:0]         out_sex,
    output logic [7:0]         out_age,
    output logic               found,
    output logic               last
);

    rtss_pkg::record_t                   table_reg [rtss_pkg::ENTRIES];
    rtss_pkg::record_t                   table_next [rtss_pkg::ENTRIES];
    logic [rtss_pkg::IDX_W-1:0]          wptr_reg;
    logic [rtss_pkg::IDX_W-1:0]          wptr_next;
    logic [15:0]                         key_reg;
    logic                                hit_reg;
    logic                                hit_next;
    rtss_pkg::record_t                   hit_rec_reg;
    rtss_pkg::record_t                   out_rec_reg;
    logic                                found_reg;
    logic                                last_reg;
    rtss_pkg::record_t                   in_rec;
    logic                                key_match;

    assign in_rec    = '{num: rec_num, name: rec_name, sex: rec_sex, age: rec_age};
    assign key_match = (table_reg[0].num == key_reg);

    always_comb
    begin
        table_next = table_reg;
        if (cmd.insert)
        begin
            table_next[wptr_reg] = in_rec;
        end
        else if (cmd.rotate)
        begin
            for (int i = 0; i < rtss_pkg::ENTRIES; i++)
            begin
                table_next[i] = table_reg[(i + 1) % rtss_pkg::ENTRIES];
            end
        end
        else if (cmd.sort_step)
        begin
            // pairs of one phase are disjoint, strict compare keeps it stable
            for (int i = 0; i < rtss_pkg::ENTRIES - 1; i++)
            begin
                if (((i % 2) == 1) == cmd.sort_odd
                    && table_reg[i].age > table_reg[i + 1].age)
                begin
                    table_next[i]     = table_reg[i + 1];
                    table_next[i + 1] = table_reg[i];
                end
            end
        end
    end

    always_comb
    begin
        wptr_next = wptr_reg;
        if (cmd.insert)
        begin
            if (wptr_reg == rtss_pkg::IDX_W'(rtss_pkg::ENTRIES - 1))
                wptr_next = '0;
            else
                wptr_next = wptr_reg + 1'b1;
        end
    end

    always_comb
    begin
        hit_next = hit_reg;
        if (cmd.clear_hit)
            hit_next = 1'b0;
        else if (cmd.scan && !hit_reg && key_match)
            hit_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rtss_pkg::ENTRIES; i++)
            begin
                table_reg[i] <= '0;
            end
            wptr_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            table_reg <= table_next;
            wptr_reg  <= wptr_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_key)
            key_reg <= search_key;
        if (cmd.scan && !hit_reg && key_match)
            hit_rec_reg <= table_reg[0];
        if (cmd.load_dump)
        begin
            out_rec_reg <= table_reg[0];
            found_reg   <= 1'b1;
            last_reg    <= cmd.dump_last;
        end
        else if (cmd.load_search)
        begin
            out_rec_reg <= hit_reg ? hit_rec_reg : '0;
            found_reg   <= hit_reg;
            last_reg    <= 1'b1;
        end
    end

    assign out_num  = out_rec_reg.num;
    assign out_name = out_rec_reg.name;
    assign out_sex  = out_rec_reg.sex;
    assign out_age  = out_rec_reg.age;
    assign found    = found_reg;
    assign last     = last_reg;

endmodule

`default_nettype wire

FILE: src/rtss_ctrl.sv
// controller state machine: action decode, sort phase and beat counting,
// output valid flag
// depends on rtss_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtss_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic [1:0]     action,
    output logic                out_valid,
    input  wire logic           out_ready,
    output rtss_pkg::cmd_t      cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SORT = 3'd1;
    localparam logic [2:0] S_DUMP = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_SRES = 3'd4;

    localparam logic [rtss_pkg::IDX_W-1:0] CNT_LAST =
        rtss_pkg::IDX_W'(rtss_pkg::ENTRIES - 1);

    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    logic [rtss_pkg::IDX_W-1:0] cnt_reg;
    logic [rtss_pkg::IDX_W-1:0] cnt_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       slot_free;
    logic                       in_beat;
    logic                       cnt_at_last;

    assign in_ready    = (state_reg == S_IDLE);
    assign in_beat     = in_valid && in_ready;
    assign slot_free   = !out_valid_reg || out_ready;
    assign cnt_at_last = (cnt_reg == CNT_LAST);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_beat)
                begin
                    case (action)
                        rtss_pkg::ACT_INSERT: cmd.insert = 1'b1;
                        rtss_pkg::ACT_DUMP:   state_next = S_DUMP;
                        rtss_pkg::ACT_SORT:   state_next = S_SORT;
                        rtss_pkg::ACT_SEARCH:
                        begin
                            cmd.latch_key = 1'b1;
                            cmd.clear_hit = 1'b1;
                            state_next    = S_SCAN;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_SORT:
            begin
                cmd.sort_step = 1'b1;
                cmd.sort_odd  = cnt_reg[0];
                if (cnt_at_last)
                begin
                    cnt_next   = '0;
                    state_next = S_DUMP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DUMP:
            begin
                if (slot_free)
                begin
                    cmd.load_dump = 1'b1;
                    cmd.dump_last = cnt_at_last;
                    cmd.rotate    = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                    if (cnt_at_last)
                        state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.rotate = 1'b1;
                cmd.scan   = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_at_last)
                    state_next = S_SRES;
            end
            S_SRES:
            begin
                if (slot_free)
                begin
                    cmd.load_search = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.load_dump || cmd.load_search)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: src/record_table_sort_search.sv
// Record table of ENTRIES records (number, name token, sex code, age), written in ring
// order. Insert gives no beat. Dump gives ENTRIES beats, one per cycle
// while out_ready is high, by rotating the table past its head entry. Sort runs ENTRIES
// odd-even compare/swap phases (stable, ascending age) and then dumps. Search rotates the
// whole table once past its head entry, then gives one beat with found and the first
// matching entry, or zero fields on a miss. The next item is taken once the last beat is
// in the output register. No clearing pass: reset zeroes the table.
// depends on rtss_pkg, rtss_ctrl, rtss_datapath
`timescale 1ns / 1ps
`default_nettype none

module record_table_sort_search (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [15:0] rec_num,
    input  wire logic [31:0] rec_name,
    input  wire logic [7:0]  rec_sex,
    input  wire logic [7:0]  rec_age,
    input  wire logic [15:0] search_key,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      out_num,
    output logic [31:0]      out_name,
    output logic [7:0]       out_sex,
    output logic [7:0]       out_age,
    output logic             found,
    output logic             last
);

    rtss_pkg::cmd_t cmd;

    rtss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    rtss_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .rec_num    (rec_num),
        .rec_name   (rec_name),
        .rec_sex    (rec_sex),
        .rec_age    (rec_age),
        .search_key (search_key),
        .out_num    (out_num),
        .out_name   (out_name),
        .out_sex    (out_sex),
        .out_age    (out_age),
        .found      (found),
        .last       (last)
    );

endmodule

`default_nettype wire

FILE: tb/record_table_sort_search_tb.sv
// self-checking testbench for record_table_sort_search: directed and random actions
// with a shadow table predicting every output beat; uses rtss_pkg and the block's rtl
`timescale 1ns / 1ps

module record_table_sort_search_tb;

    import rtss_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int RANDOM_ITEMS   = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 48;

    typedef struct packed {
        record_t rec;
        logic    hit;
        logic    tail;
    } table_beat_t;

    class record_table_check;
        record_t     shadow_table [ENTRIES];
        int unsigned shadow_wptr;
        table_beat_t due_beats [$];
        int          errors;
        int          beats_seen;
        int          inserts;
        int          dumps;
        int          sorts;
        int          hits;
        int          misses;

        function new();
            foreach (shadow_table[i])
                shadow_table[i] = '0;
            shadow_wptr = 0;
            errors      = 0;
            beats_seen  = 0;
            inserts     = 0;
            dumps       = 0;
            sorts       = 0;
            hits        = 0;
            misses      = 0;
        endfunction

        function void queue_dump();
            table_beat_t b;
            for (int i = 0; i < ENTRIES; i++)
            begin
                b.rec  = shadow_table[i];
                b.hit  = 1'b1;
                b.tail = (i == ENTRIES - 1);
                due_beats.push_back(b);
            end
        endfunction

        // stable bubble sort on age, early exit when a sweep swaps nothing
        function void sort_by_age();
            record_t t;
            bit      swapped;
            for (int sweep = 0; sweep < ENTRIES - 1; sweep++)
            begin
                swapped = 1'b0;
                for (int j = 0; j < ENTRIES - 1 - sweep; j++)
                begin
                    if (shadow_table[j].age > shadow_table[j + 1].age)
                    begin
                        t                   = shadow_table[j];
                        shadow_table[j]     = shadow_table[j + 1];
                        shadow_table[j + 1] = t;
                        swapped             = 1'b1;
                    end
                end
                if (!swapped)
                    break;
            end
        endfunction

        function void apply_action(logic [1:0] act, record_t rec, logic [15:0] key);
            table_beat_t b;
            int          hit_at;
            case (act)
                ACT_INSERT:
                begin
                    shadow_table[shadow_wptr] = rec;
                    shadow_wptr = (shadow_wptr + 1) % ENTRIES;
                    inserts++;
                end
                ACT_DUMP:
                begin
                    queue_dump();
                    dumps++;
                end
                ACT_SORT:
                begin
                    sort_by_age();
                    queue_dump();
                    sorts++;
                end
                default:
                begin
                    hit_at = -1;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (hit_at < 0 && shadow_table[i].num == key)
                            hit_at = i;
                    end
                    b.rec  = (hit_at >= 0) ? shadow_table[hit_at] : record_t'('0);
                    b.hit  = (hit_at >= 0);
                    b.tail = 1'b1;
                    due_beats.push_back(b);
                    if (hit_at >= 0)
                        hits++;
                    else
                        misses++;
                end
            endcase
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("%0t ns: %s", $time, what);
        endtask

        task check_beat(table_beat_t got);
            table_beat_t want;
            beats_seen++;
            if (due_beats.size() == 0)
            begin
                report_mismatch($sformatf("beat with nothing pending, out_num %h", got.rec.num));
                return;
            end
            want = due_beats.pop_front();
            if (got.rec.num !== want.rec.num)
                report_mismatch($sformatf("out_num %h, want %h", got.rec.num, want.rec.num));
            if (got.rec.name !== want.rec.name)
                report_mismatch($sformatf("out_name %h, want %h", got.rec.name, want.rec.name));
            if (got.rec.sex !== want.rec.sex)
                report_mismatch($sformatf("out_sex %h, want %h", got.rec.sex, want.rec.sex));
            if (got.rec.age !== want.rec.age)
                report_mismatch($sformatf("out_age %h, want %h", got.rec.age, want.rec.age));
            if (got.hit !== want.hit)
                report_mismatch($sformatf("found %b, want %b", got.hit, want.hit));
            if (got.tail !== want.tail)
                report_mismatch($sformatf("last %b, want %b", got.tail, want.tail));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [15:0] rec_num;
    logic [31:0] rec_name;
    logic [7:0]  rec_sex;
    logic [7:0]  rec_age;
    logic [15:0] search_key;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] out_num;
    logic [31:0] out_name;
    logic [7:0]  out_sex;
    logic [7:0]  out_age;
    logic        found;
    logic        last;

    record_table_check sb = new();
    int  burst_left = 0;
    bit  steady     = 1'b0;
    int  quiet      = 0;
    int  rx_cycle   = 0;

    record_table_sort_search i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic send_item(input logic [1:0] act, input record_t rec, input logic [15:0] key);
        @(negedge clk);
        in_valid   <= 1'b1;
        action     <= act;
        rec_num    <= rec.num;
        rec_name   <= rec.name;
        rec_sex    <= rec.sex;
        rec_age    <= rec.age;
        search_key <= key;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.apply_action(act, rec, key);
    endtask

    task automatic sender_idle();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
    endtask

    // small numbers and coarse ages make duplicate keys and age ties common
    function automatic record_t random_record();
        record_t r;
        r.num  = 16'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 65535));
        r.name = $urandom;
        r.sex  = 8'($urandom_range(0, 255));
        r.age  = 8'($urandom_range(0, 1) ? $urandom_range(0, 3) * 8 : $urandom_range(0, 255));
        return r;
    endfunction

    function automatic logic [15:0] random_key();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return sb.shadow_table[$urandom_range(0, ENTRIES - 1)].num;
        else if (pick < 8)
            return 16'($urandom_range(0, 15));
        return 16'($urandom_range(0, 65535));
    endfunction

    // receiver: no-stall, random, periodic and light random stretches
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            case ((rx_cycle / 150) % 4)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 9) < 7);
                2: out_ready <= ((rx_cycle % 7) >= 3);
                default: out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_beat({out_num, out_name, out_sex, out_age, found, last});
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else if (quiet + 1 >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: %0d cycles without a beat", quiet + 1);
            $display("record_table_sort_search: mismatch");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = ACT_INSERT;
        rec_num    = '0;
        rec_name   = '0;
        rec_sex    = '0;
        rec_age    = '0;
        search_key = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // empty table, then extremes, ties, duplicate numbers and pointer wrap
        send_item(ACT_DUMP, '0, '0);
        send_item(ACT_SEARCH, '0, 16'h0000);
        send_item(ACT_SEARCH, '0, 16'hFFFF);
        send_item(ACT_INSERT, {16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF}, '0);
        send_item(ACT_INSERT, {16'h0001, 32'h0000_0000, 8'h00, 8'h00}, '0);
        send_item(ACT_INSERT, {16'h1234, 32'hA5A5_A5A5, 8'h4D, 8'h20}, '0);
        send_item(ACT_INSERT, {16'h5678, 32'h5A5A_5A5A, 8'h46, 8'h20}, '0);
        send_item(ACT_INSERT, {16'h1234, 32'h0F0F_0F0F, 8'h46, 8'h10}, '0);
        send_item(ACT_SEARCH, '0, 16'h1234);
        send_item(ACT_SEARCH, '0, 16'hFFFF);
        send_item(ACT_SORT, '0, '0);
        send_item(ACT_SEARCH, '0, 16'h1234);
        send_item(ACT_INSERT, {16'h0010, 32'h8000_0001, 8'h4D, 8'h20}, '0);
        send_item(ACT_INSERT, {16'h0020, 32'h7FFF_FFFE, 8'h46, 8'h05}, '0);
        send_item(ACT_INSERT, {16'h0030, 32'h1357_9BDF, 8'h80, 8'hFF}, '0);
        send_item(ACT_INSERT, {16'h0040, 32'h2468_ACE0, 8'h01, 8'h00}, '0);
        send_item(ACT_INSERT, {16'h0050, 32'hDEAD_BEEF, 8'h7F, 8'h20}, '0);
        send_item(ACT_SEARCH, '0, 16'h0000);
        send_item(ACT_SORT, '0, '0);
        send_item(ACT_SEARCH, '0, 16'h4242);
        send_item(ACT_DUMP, '0, '0);
        send_item(ACT_SORT, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            int      pick;
            logic [1:0] act;
            steady = (n >= 60 && n < 90);
            sender_idle();
            pick = $urandom_range(0, 99);
            act  = (pick < 50) ? ACT_INSERT : (pick < 62) ? ACT_DUMP :
                   (pick < 77) ? ACT_SORT : ACT_SEARCH;
            send_item(act, random_record(), random_key());
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.due_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d inserts, %0d dumps, %0d sorts, %0d searches (%0d hits, %0d misses)",
                 sb.inserts, sb.dumps, sb.sorts, sb.hits + sb.misses, sb.hits, sb.misses);
        $display("%0d output beats checked, %0d mismatches", sb.beats_seen, sb.errors);
        if (sb.errors == 0)
            $display("record_table_sort_search: match");
        else
            $display("record_table_sort_search: mismatch");
        $finish;
    end

endmodule
